// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and sigma functions for the sha-256 digest
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;

  // controls from the sequencer to the compression datapath
  typedef struct packed {
    logic       load;       // copy hash words into a..h
    logic       sched_en;   // schedule stage produces one word
    logic [5:0] sched_idx;
    logic       round_en;   // one compression round
    logic [5:0] round_idx;
    logic       fold;       // add a..h into the hash words
    logic       reinit;     // back to the initial hash values
  } comp_ctrl_t;

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    return K_TAB[idx];
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    return IV_TAB[idx];
  endfunction

  function automatic word_t big_s0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_s0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_s1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== sv/sha_sched_ram.sv =====
// ----------------------------------------------------------------------------
// sha_sched_ram
// 16-word message schedule ring, one write port and two registered read ports
// ----------------------------------------------------------------------------
module sha_sched_ram
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  logic [3:0] wr_addr,
  input  word_t      wr_data,
  input  logic [3:0] rd_addr_a,
  input  logic [3:0] rd_addr_b,
  output word_t      rd_data_a,
  output word_t      rd_data_b
);

  word_t mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== sv/sha_compress.sv =====
// ----------------------------------------------------------------------------
// sha_compress
// schedule stage, round datapath and hash words of the sha-256 digest
// ----------------------------------------------------------------------------
module sha_compress
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  comp_ctrl_t ctrl,
  input  word_t      rd_data_a,
  input  word_t      rd_data_b,
  output word_t      sched_word,
  input  logic [2:0] out_sel,
  output word_t      digest_word
);

  word_t hash [8];
  word_t v [8];
  word_t w_cur;    // schedule word of the current round
  word_t w_old;    // the one before it
  word_t w_tap16;  // ring word sixteen back, kept from the second read port
  word_t t1;
  word_t t2;

  // first sixteen words come straight from the ring
  always_comb begin
    if (ctrl.sched_idx[5:4] == 2'b00) begin
      sched_word = rd_data_a;
    end else begin
      sched_word = small_s1(w_old) + rd_data_a + small_s0(rd_data_b) + w_tap16;
    end
  end

  always_comb begin
    t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
       + round_k(ctrl.round_idx) + w_cur;
    t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (ctrl.sched_en) begin
      w_cur   <= sched_word;
      w_old   <= w_cur;
      w_tap16 <= rd_data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= init_hash(3'(i));
        v[i]    <= '0;
      end
    end else begin
      if (ctrl.reinit) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= init_hash(3'(i));
        end
      end else if (ctrl.fold) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end
      if (ctrl.load) begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= hash[i];
        end
      end else if (ctrl.round_en) begin
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
      end
    end
  end

  assign digest_word = hash[out_sel];

endmodule

// ===== sv/sha256_digest.sv =====
// ----------------------------------------------------------------------------
// sha256_digest
// streaming sha-256 over a byte message, digest emitted as eight words
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall   data_byte, has_byte, is_last
//  out      source     out_valid / out_stall digest_word, word_last
//
//  a byte transfer is accepted whenever the block is idle; the byte that
//  fills a 64-byte block starts a compression (ring read in the cycle
//  before the schedule stage, schedule in the cycle before the round,
//  then the fold); a closing transfer adds 9 to 72 padding bytes, one byte
//  a cycle, and one or two compressions, then eight output transfers
//  in_stall is high whenever the block is not idle; out_stall holds the word
//  reset restores the initial hash values and clears the control state;
//  the schedule ring is not cleared
// ----------------------------------------------------------------------------
module sha256_digest
  import sha_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        word_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [6:0] STEP_SCHED_LAST  = 7'd64;
  localparam logic [6:0] STEP_ROUND_FIRST = 7'd2;
  localparam logic [6:0] STEP_ROUND_LAST  = 7'd65;
  localparam logic [6:0] STEP_FOLD        = 7'd66;
  localparam logic [7:0] PAD_BYTE         = 8'h80;

  logic [1:0]             state;
  logic [5:0]             pos;
  logic [LENGTH_BITS-1:0] bit_count;
  logic                   closing;
  logic                   mark_done;   // the 0x80 byte is in
  logic                   len_phase;
  logic                   pad_done;
  logic [2:0]             len_idx;
  logic [23:0]            pack;
  logic [6:0]             step;
  logic [2:0]             out_idx;

  logic       in_xfer;
  logic       out_xfer;
  logic       absorb;
  logic [7:0] absorb_byte;
  logic       len_byte_sel;
  logic [63:0] len64;
  logic [7:0] len_byte;

  comp_ctrl_t ctrl;
  word_t      sched_word;
  word_t      rd_data_a;
  word_t      rd_data_b;
  logic       ram_we;
  logic [3:0] ram_wr_addr;
  word_t      ram_wr_data;
  logic [3:0] ram_rd_addr_a;
  logic [3:0] ram_rd_addr_b;
  logic [5:0] rd_idx;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign word_last = (out_idx == 3'd7);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // length field is always 64 bits, upper bits zero for a short counter
  always_comb begin
    len64 = '0;
    len64[LENGTH_BITS-1:0] = bit_count;
  end
  assign len_byte     = len64[{~len_idx, 3'b000} +: 8];
  assign len_byte_sel = mark_done && (len_phase || pos == 6'd56);

  always_comb begin
    absorb      = 1'b0;
    absorb_byte = data_byte;
    if (state == ST_IDLE) begin
      absorb = in_xfer && has_byte;
    end else if (state == ST_PAD) begin
      absorb = 1'b1;
      if (!mark_done) begin
        absorb_byte = PAD_BYTE;
      end else if (len_byte_sel) begin
        absorb_byte = len_byte;
      end else begin
        absorb_byte = 8'h00;
      end
    end
  end

  // sequencer controls for the compression pass
  always_comb begin
    ctrl.load      = (state == ST_COMP) && (step == '0);
    ctrl.sched_en  = (state == ST_COMP) && (step != '0) && (step <= STEP_SCHED_LAST);
    ctrl.sched_idx = 6'(step - 7'd1);
    ctrl.round_en  = (state == ST_COMP) && (step >= STEP_ROUND_FIRST)
                   && (step <= STEP_ROUND_LAST);
    ctrl.round_idx = 6'(step - STEP_ROUND_FIRST);
    ctrl.fold      = (state == ST_COMP) && (step == STEP_FOLD);
    ctrl.reinit    = out_xfer && word_last;
  end

  // ring reads are issued in the cycle before the schedule stage needs them
  assign rd_idx        = step[5:0];
  assign ram_rd_addr_a = (rd_idx[5:4] == 2'b00) ? rd_idx[3:0] : rd_idx[3:0] - 4'd7;
  assign ram_rd_addr_b = rd_idx[3:0] + 4'd1;

  always_comb begin
    if (state == ST_COMP) begin
      ram_we      = ctrl.sched_en && (ctrl.sched_idx[5:4] != 2'b00);
      ram_wr_addr = ctrl.sched_idx[3:0];
      ram_wr_data = sched_word;
    end else begin
      ram_we      = absorb && (pos[1:0] == 2'b11);
      ram_wr_addr = pos[5:2];
      ram_wr_data = {pack, absorb_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (absorb) begin
      pack <= {pack[15:0], absorb_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      bit_count <= '0;
      closing   <= 1'b0;
      mark_done <= 1'b0;
      len_phase <= 1'b0;
      pad_done  <= 1'b0;
      len_idx   <= '0;
      step      <= '0;
      out_idx   <= '0;
    end else begin
      if (absorb) begin
        pos <= pos + 6'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            closing <= is_last;
            if (has_byte) begin
              bit_count <= bit_count + LENGTH_BITS'(8);
            end
            if (has_byte && pos == 6'd63) begin
              state <= ST_COMP;
              step  <= '0;
            end else if (is_last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          mark_done <= 1'b1;
          if (len_byte_sel) begin
            len_phase <= 1'b1;
            len_idx   <= len_idx + 3'd1;
            if (len_idx == 3'd7) begin
              pad_done <= 1'b1;
            end
          end
          if (pos == 6'd63) begin
            state <= ST_COMP;
            step  <= '0;
          end
        end
        ST_COMP: begin
          step <= step + 7'd1;
          if (step == STEP_FOLD) begin
            if (pad_done) begin
              state   <= ST_OUT;
              out_idx <= '0;
            end else if (closing) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_xfer) begin
            out_idx <= out_idx + 3'd1;
            if (word_last) begin
              state     <= ST_IDLE;
              closing   <= 1'b0;
              mark_done <= 1'b0;
              len_phase <= 1'b0;
              pad_done  <= 1'b0;
              len_idx   <= '0;
              pos       <= '0;
              bit_count <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  sha_sched_ram u_ram (
    .clk       (clk),
    .we        (ram_we),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_addr_a (ram_rd_addr_a),
    .rd_addr_b (ram_rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  sha_compress u_comp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b),
    .sched_word  (sched_word),
    .out_sel     (out_idx),
    .digest_word (digest_word)
  );

`ifndef ASSERT_OFF
  a_ring_no_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == ST_COMP) |->
      (ram_wr_addr != ram_rd_addr_a && ram_wr_addr != ram_rd_addr_b))
    else $error("schedule ring written at an address being read");

  a_comp_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP) |-> (pos == 6'd0))
    else $error("compression started off a block boundary");

  a_digest_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && word_last) |=>
      (!out_valid && bit_count == '0 && !closing))
    else $error("message state not cleared after the last digest transfer");
`endif

endmodule
